[design/hsl_pkg.sv]
// Shared types and constants for the HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

   // Pipeline depth from input register to result register.
   localparam int NUM_STAGES = 6;

   // Field widths.
   localparam int ANG_W  = 9;   // hue and wrapped angles, 0..360
   localparam int FRAC_W = 9;   // saturation and lightness, 0..256
   localparam int VAL_W  = 17;  // q, p and channel values, 1.0 = 65536
   localparam int FAC_W  = 6;   // ramp factor, 0..60
   localparam int PROD_W = 22;  // ramp product, below 60 * 65537
   localparam int QIN_W  = 20;  // ramp product divided by four
   localparam int RCP_W  = 21;  // reciprocal multiplier width
   localparam int CHAN_W = 8;   // output channel

   localparam logic [ANG_W-1:0]  HUE_FULL = 9'd360;
   localparam logic [FRAC_W-1:0] NORM_ONE = 9'd256;

   // Division by 15 as a multiply: floor(y * RCP_MUL >> RCP_SHIFT) is exact for y < 2^20.
   localparam logic [RCP_W-1:0] RCP_MUL   = 21'd1118482;
   localparam int               RCP_SHIFT = 24;

   // Channel segment codes.
   localparam logic [1:0] SEL_RAMP_UP = 2'd0;
   localparam logic [1:0] SEL_Q       = 2'd1;
   localparam logic [1:0] SEL_RAMP_DN = 2'd2;
   localparam logic [1:0] SEL_P       = 2'd3;

   // Per-stage load strobes for the channel back end.
   typedef struct packed {
      logic ld_mul;
      logic ld_rcp;
      logic ld_val;
      logic ld_out;
   } hsl_ctl_type;

endpackage

`default_nettype wire

[design/hsl_chan.sv]
// Back end of one color channel: ramp multiply, divide by 60, segment select and 255 scale.
`timescale 1ns / 1ps
`default_nettype none

module hsl_chan (
   input  wire logic                           clock,
   input  wire hsl_pkg::hsl_ctl_type           ctl,
   input  wire logic [hsl_pkg::VAL_W-1:0]      q_val,
   input  wire logic [hsl_pkg::VAL_W-1:0]      p_val,
   input  wire logic [hsl_pkg::VAL_W-1:0]      d_val,
   input  wire logic [1:0]                     sel,
   input  wire logic [hsl_pkg::FAC_W-1:0]      fac,
   output logic      [hsl_pkg::CHAN_W-1:0]     chan
);
   import hsl_pkg::*;

   localparam int RPROD_W = QIN_W + RCP_W;

   logic [PROD_W-1:0]  prod_ff;
   logic [VAL_W-1:0]   q3_ff, p3_ff, q4_ff, p4_ff;
   logic [1:0]         sel3_ff, sel4_ff;
   logic [VAL_W-1:0]   quo4_ff;
   logic [VAL_W-1:0]   val5_ff;
   logic [CHAN_W-1:0]  chan6_ff;

   logic [RPROD_W-1:0] rprod_in;
   logic [VAL_W-1:0]   val5_in;
   logic [VAL_W+7:0]   scaled_in;

   // Ramp product (q - p) times the factor.
   always_ff @(posedge clock) begin
      if (ctl.ld_mul) begin
         prod_ff <= PROD_W'(d_val * fac);
         q3_ff   <= q_val;
         p3_ff   <= p_val;
         sel3_ff <= sel;
      end
   end

   // x / 60 = (x / 4) / 15, the last step through a reciprocal.
   assign rprod_in = RPROD_W'(prod_ff[QIN_W+1:2]) * RPROD_W'(RCP_MUL);

   always_ff @(posedge clock) begin
      if (ctl.ld_rcp) begin
         quo4_ff <= rprod_in[RCP_SHIFT+VAL_W-1:RCP_SHIFT];
         q4_ff   <= q3_ff;
         p4_ff   <= p3_ff;
         sel4_ff <= sel3_ff;
      end
   end

   always_comb begin
      case (sel4_ff)
         SEL_RAMP_UP, SEL_RAMP_DN: val5_in = p4_ff + quo4_ff;
         SEL_Q:                    val5_in = q4_ff;
         default:                  val5_in = p4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_val) begin
         val5_ff <= val5_in;
      end
   end

   // v * 255 = (v << 8) - v, then keep the integer part. With v at most 1.0
   // the product stays below 2^24, so the integer part fits in eight bits.
   assign scaled_in = {val5_ff, 8'd0} - {8'd0, val5_ff};

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         chan6_ff <= scaled_in[16+CHAN_W-1:16];
      end
   end

   assign chan = chan6_ff;

endmodule

`default_nettype wire

[design/hsl_to_rgb_converter.sv]
// Top level of the HSL to RGB converter: input conditioning, q and p, angles and flow control.
// An accepted item passes the stage registers in order: conditioned inputs, q and p with
// the angles, ramp product, quotient, channel value, and the result on the rsp_ ports.
// Throughput is one item per clock while rsp_ready stays high; each of the six stages
// holds one item and moves it on whenever the stage after it is empty or moving as well.
// Synchronous active-high reset empties every stage; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [hsl_pkg::ANG_W-1:0]       req_hue,
   input  wire logic [hsl_pkg::FRAC_W-1:0]      req_saturation,
   input  wire logic [hsl_pkg::FRAC_W-1:0]      req_lightness,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [hsl_pkg::CHAN_W-1:0]      rsp_red,
   output logic      [hsl_pkg::CHAN_W-1:0]      rsp_green,
   output logic      [hsl_pkg::CHAN_W-1:0]      rsp_blue
);
   import hsl_pkg::*;

   // Classify a wrapped angle (0..360) into its segment and ramp factor.
   // An angle of exactly 360 falls into the final segment and takes p.
   function automatic logic [FAC_W+1:0] classify(input logic [ANG_W-1:0] t);
      logic [ANG_W-1:0] down;
      logic [1:0]       s;
      logic [FAC_W-1:0] f;
      down = 9'd240 - t;
      f    = '0;
      if (t < 9'd60) begin
         s = SEL_RAMP_UP;
         f = t[FAC_W-1:0];
      end else if (t < 9'd180) begin
         s = SEL_Q;
      end else if (t < 9'd240) begin
         s = SEL_RAMP_DN;
         f = down[FAC_W-1:0];
      end else begin
         s = SEL_P;
      end
      return {s, f};
   endfunction

   // ------------------------------------------------------------------
   // Flow control. A stage loads when it is empty or the stage after it
   // loads in the same cycle, so bubbles close up and a stalled output
   // does not stop items from entering while earlier stages have room.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] rdy;

   always_comb begin
      rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ------------------------------------------------------------------
   // Stage 1: wrap the hue, saturate the fractions, form l * s.
   // ------------------------------------------------------------------
   logic [ANG_W-1:0]  h1_ff, h1_in;
   logic [FRAC_W-1:0] s1_ff, s1_in, l1_ff, l1_in;
   logic [VAL_W-1:0]  ls1_ff;

   assign h1_in = (req_hue >= HUE_FULL) ? req_hue - HUE_FULL : req_hue;
   assign s1_in = (req_saturation > NORM_ONE) ? NORM_ONE : req_saturation;
   assign l1_in = (req_lightness > NORM_ONE) ? NORM_ONE : req_lightness;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         h1_ff  <= h1_in;
         s1_ff  <= s1_in;
         l1_ff  <= l1_in;
         ls1_ff <= VAL_W'(l1_in * s1_in);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: q and p with 16 fractional bits, and the three channel
   // angles. Zero saturation needs no special path: q and p both equal
   // l * 256 and every channel lands on (l * 255) >> 8.
   // ------------------------------------------------------------------
   logic [VAL_W+1:0]  l256, s256, l512, q_raw, p_raw;
   logic [VAL_W-1:0]  q_in, p_in;
   logic [ANG_W:0]    t_red_sum;
   logic [ANG_W-1:0]  t_red, t_green, t_blue;
   logic [FAC_W+1:0]  cls_red, cls_green, cls_blue;

   always_comb begin
      l256 = {2'd0, l1_ff, 8'd0};
      s256 = {2'd0, s1_ff, 8'd0};
      l512 = {1'b0, l1_ff, 9'd0};
      if (l1_ff < 9'd128) begin
         q_raw = l256 + {2'd0, ls1_ff};
      end else begin
         q_raw = l256 + s256 - {2'd0, ls1_ff};
      end
      // p = 2 * l - q, floored at zero; q is then kept no smaller than p.
      p_raw = (l512 < q_raw) ? '0 : l512 - q_raw;
      p_in  = p_raw[VAL_W-1:0];
      q_in  = (q_raw < p_raw) ? p_raw[VAL_W-1:0] : q_raw[VAL_W-1:0];

      // Red is hue + 120, wrapped only when past 360; blue is hue - 120.
      t_red_sum = {1'b0, h1_ff} + 10'd120;
      t_red     = (t_red_sum > 10'd360) ? ANG_W'(t_red_sum - 10'd360)
                                        : t_red_sum[ANG_W-1:0];
      t_green   = h1_ff;
      t_blue    = (h1_ff < 9'd120) ? h1_ff + 9'd240 : h1_ff - 9'd120;

      cls_red   = classify(t_red);
      cls_green = classify(t_green);
      cls_blue  = classify(t_blue);
   end

   logic [VAL_W-1:0]  q2_ff, p2_ff, d2_ff;
   logic [FAC_W+1:0]  cls_red_ff, cls_green_ff, cls_blue_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         q2_ff        <= q_in;
         p2_ff        <= p_in;
         d2_ff        <= q_in - p_in;
         cls_red_ff   <= cls_red;
         cls_green_ff <= cls_green;
         cls_blue_ff  <= cls_blue;
      end
   end

   // ------------------------------------------------------------------
   // Stages 3 to 6: one back end per channel, sharing the load strobes.
   // ------------------------------------------------------------------
   hsl_ctl_type ctl;

   assign ctl.ld_mul = rdy[2];
   assign ctl.ld_rcp = rdy[3];
   assign ctl.ld_val = rdy[4];
   assign ctl.ld_out = rdy[5];

   hsl_chan u_chan_red (
      .clock (clock),
      .ctl   (ctl),
      .q_val (q2_ff),
      .p_val (p2_ff),
      .d_val (d2_ff),
      .sel   (cls_red_ff[FAC_W+1:FAC_W]),
      .fac   (cls_red_ff[FAC_W-1:0]),
      .chan  (rsp_red)
   );

   hsl_chan u_chan_green (
      .clock (clock),
      .ctl   (ctl),
      .q_val (q2_ff),
      .p_val (p2_ff),
      .d_val (d2_ff),
      .sel   (cls_green_ff[FAC_W+1:FAC_W]),
      .fac   (cls_green_ff[FAC_W-1:0]),
      .chan  (rsp_green)
   );

   hsl_chan u_chan_blue (
      .clock (clock),
      .ctl   (ctl),
      .q_val (q2_ff),
      .p_val (p2_ff),
      .d_val (d2_ff),
      .sel   (cls_blue_ff[FAC_W+1:FAC_W]),
      .fac   (cls_blue_ff[FAC_W-1:0]),
      .chan  (rsp_blue)
   );

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The cycle after reset every stage is empty.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // A full pipeline with a stalled output must refuse new items.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ready) |-> !req_ready)
      else $error("item taken while pipeline is full and stalled");

   // Conditioned inputs stay in range.
   a_stage1_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (h1_ff < HUE_FULL && s1_ff <= NORM_ONE && l1_ff <= NORM_ONE))
      else $error("stage 1 values out of range");

   // The ramp span is consistent with q and p.
   a_stage2_order: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (q2_ff >= p2_ff && d2_ff == q2_ff - p2_ff))
      else $error("q below p or bad span in stage 2");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the HSL to RGB pixel converter.
`timescale 1ns / 1ps

module tb;

   import hsl_pkg::*;

   // One queued request: a pixel to send, or a marker that holds the sender
   // until every pixel already sent has come back.
   typedef struct {
      logic [ANG_W-1:0]  hue;
      logic [FRAC_W-1:0] sat;
      logic [FRAC_W-1:0] light;
      bit                drain;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [ANG_W-1:0]  req_hue        = '0;
   logic [FRAC_W-1:0] req_saturation = '0;
   logic [FRAC_W-1:0] req_lightness  = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;

   pixel_req_type pixel_queue[$];
   rgb_type       rgb_expected[$];

   int  pixels_in    = 0;
   int  pixels_out   = 0;
   int  mismatches   = 0;
   int  gray_pixels  = 0;
   int  wrapped_hues = 0;
   int  clamped_frac = 0;
   bit  req_taken    = 1'b0;
   bit  drain_wait   = 1'b0;
   int  send_gap     = 0;
   int  stall_left   = 0;
   int  hold_left    = 0;
   bit  long_hold_done = 1'b0;

   hsl_to_rgb_converter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #1 clock = ~clock;

   // One channel of the piecewise HSL curve. The angle is the hue plus the
   // channel offset; it is folded back into 0..360, and an angle of exactly
   // 360 falls through to the flat p segment.
   function automatic logic [CHAN_W-1:0] channel_level(int angle, int unsigned q,
                                                       int unsigned p);
      int unsigned diff;
      int unsigned level;
      diff = q - p;
      if (angle < 0)
         angle += 360;
      if (angle > 360)
         angle -= 360;
      if (angle < 60)
         level = p + (diff * int'(angle)) / 60;
      else if (angle < 180)
         level = q;
      else if (angle < 240)
         level = p + (diff * int'(240 - angle)) / 60;
      else
         level = p;
      return CHAN_W'((level * 255) >> 16);
   endfunction

   // Expected color of one pixel. q and p carry 16 fractional bits, so with
   // 8-bit fractions on the inputs every product below is exact.
   function automatic rgb_type hsl_to_rgb_expect(logic [ANG_W-1:0] hue_in,
                                                 logic [FRAC_W-1:0] sat_in,
                                                 logic [FRAC_W-1:0] light_in);
      int unsigned h;
      int unsigned s;
      int unsigned l;
      int unsigned q;
      int unsigned p;
      longint      p_wide;
      rgb_type     rgb;
      h = hue_in;
      s = sat_in;
      l = light_in;
      // Hues of 360 and up wrap once; fractions above one are held at one.
      if (h >= HUE_FULL)
         h -= HUE_FULL;
      if (s > NORM_ONE)
         s = NORM_ONE;
      if (l > NORM_ONE)
         l = NORM_ONE;
      if (s == 0) begin
         // No saturation: every channel is the same gray level.
         rgb.red   = CHAN_W'((l * 255) >> 8);
         rgb.green = rgb.red;
         rgb.blue  = rgb.red;
         return rgb;
      end
      if (l < 128)
         q = l * 256 + l * s;
      else
         q = l * 256 + s * 256 - l * s;
      p_wide = longint'(2 * l * 256) - longint'(q);
      if (p_wide < 0)
         p_wide = 0;
      p = 32'(p_wide);
      if (q < p)
         q = p;
      rgb.red   = channel_level(int'(h) + 120, q, p);
      rgb.green = channel_level(int'(h), q, p);
      rgb.blue  = channel_level(int'(h) - 120, q, p);
      return rgb;
   endfunction

   function automatic bit channel_matches(string chan, logic [CHAN_W-1:0] want,
                                          logic [CHAN_W-1:0] got);
      if (want !== got) begin
         $display("%0t: pixel %0d %s channel expected %0d, actual %0d",
                  $time, pixels_out, chan, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic add_pixel(int h, int s, int l);
      pixel_req_type pix;
      pix.hue   = ANG_W'(h);
      pix.sat   = FRAC_W'(s);
      pix.light = FRAC_W'(l);
      pix.drain = 1'b0;
      pixel_queue.push_back(pix);
   endtask

   task automatic add_drain();
      pixel_req_type pix;
      pix.hue   = '0;
      pix.sat   = '0;
      pix.light = '0;
      pix.drain = 1'b1;
      pixel_queue.push_back(pix);
   endtask

   // Random fraction: mostly inside 1..256, with zero, one and the
   // out-of-range codes above one mixed in.
   function automatic int random_fraction();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return 0;
      else if (pick < 14)
         return NORM_ONE;
      else if (pick < 20)
         return $urandom_range(NORM_ONE + 1, (1 << FRAC_W) - 1);
      return $urandom_range(1, NORM_ONE);
   endfunction

   // Sample both handshakes at the rising edge. Every accepted item gets its
   // expected color queued; every accepted result is checked against the
   // oldest expectation.
   always @(posedge clock) begin
      rgb_type want;
      bit      ok;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (rgb_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               mismatches++;
            end else begin
               want = rgb_expected.pop_front();
               ok   = channel_matches("red", want.red, rsp_red);
               ok   = channel_matches("green", want.green, rsp_green) && ok;
               ok   = channel_matches("blue", want.blue, rsp_blue) && ok;
               if (!ok)
                  mismatches++;
            end
            pixels_out++;
         end
         if (req_valid && req_ready) begin
            rgb_expected.push_back(hsl_to_rgb_expect(req_hue, req_saturation,
                                                     req_lightness));
            if (req_saturation == 0)
               gray_pixels++;
            if (req_hue >= HUE_FULL)
               wrapped_hues++;
            if (req_saturation > NORM_ONE || req_lightness > NORM_ONE)
               clamped_frac++;
            pixels_in++;
         end
      end
   end

   // Sender. An item on the port is held until it is taken. Between items it
   // may idle for a short burst, except in every third window of 70 pixels
   // and near the end of the run. A drain marker stops it until all results
   // are back.
   always @(negedge clock) begin
      pixel_req_type pix;
      bit            next_valid;
      bit            may_idle;
      if (!reset) begin
         next_valid = req_valid;
         may_idle   = pixel_queue.size() > 120 && ((pixels_in / 70) % 3 != 1);
         if (req_valid && !req_taken) begin
            next_valid = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            next_valid = 1'b0;
         end else if (drain_wait) begin
            if (rgb_expected.size() == 0)
               drain_wait = 1'b0;
            next_valid = 1'b0;
         end else if (pixel_queue.size() == 0) begin
            next_valid = 1'b0;
         end else if (may_idle && $urandom_range(0, 5) == 0) begin
            send_gap   = $urandom_range(0, 4);
            next_valid = 1'b0;
         end else begin
            pix = pixel_queue.pop_front();
            if (pix.drain) begin
               drain_wait = 1'b1;
               next_valid = 1'b0;
            end else begin
               next_valid = 1'b1;
               req_hue        <= pix.hue;
               req_saturation <= pix.sat;
               req_lightness  <= pix.light;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver. Once, after 400 pixels have gone in, it holds rsp_ready low until its hold
   // counter runs out while the sender keeps offering, so the pipeline fills and the
   // input stalls. Otherwise it stalls in short random bursts, with quiet
   // windows and a quiet tail.
   always @(negedge clock) begin
      bit next_ready;
      bit may_stall;
      if (!reset) begin
         may_stall = pixel_queue.size() > 120 && ((pixels_out / 90) % 3 != 2);
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!long_hold_done && pixels_in >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = 59;
            next_ready     = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (may_stall && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 4);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ready <= next_ready;
      end
   end

   initial begin
      // Directed pixels: hue at the segment borders and range ends, gray,
      // full and clamped saturation and lightness, and the red channel
      // landing on exactly 360 degrees (hue 240).
      add_pixel(0, 256, 128);
      add_pixel(59, 256, 128);
      add_pixel(60, 256, 128);
      add_pixel(179, 200, 100);
      add_pixel(180, 200, 100);
      add_pixel(239, 200, 160);
      add_pixel(240, 200, 160);
      add_pixel(120, 128, 128);
      add_pixel(359, 256, 256);
      add_pixel(360, 256, 128);
      add_pixel(511, 100, 60);
      add_pixel(300, 0, 0);
      add_pixel(45, 0, 256);
      add_pixel(200, 0, 511);
      add_pixel(10, 0, 137);
      add_pixel(90, 511, 127);
      add_pixel(270, 257, 128);
      add_pixel(150, 1, 1);
      add_pixel(330, 256, 0);
      add_pixel(30, 511, 511);
      add_pixel(210, 77, 300);
      add_pixel(255, 1, 255);
      add_drain();
      for (int i = 0; i < 1300; i++) begin
         if (i == 650)
            add_drain();
         if ($urandom_range(0, 99) < 85)
            add_pixel($urandom_range(0, HUE_FULL - 1), random_fraction(),
                      random_fraction());
         else
            add_pixel($urandom_range(HUE_FULL, (1 << ANG_W) - 1), random_fraction(),
                      random_fraction());
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pixel_queue.size() != 0 || drain_wait || req_valid)
         @(posedge clock);
      while (rgb_expected.size() != 0)
         @(posedge clock);
      // Run on past the pipeline depth to catch stray results.
      repeat (NUM_STAGES * 3) @(posedge clock);

      $display("Converted %0d pixels: %0d gray, %0d with hue wrapped,",
               pixels_in, gray_pixels, wrapped_hues);
      $display("%0d with clamped fractions; results checked: %0d, mismatches: %0d.",
               clamped_frac, pixels_out, mismatches);
      if (mismatches == 0 && pixels_out == pixels_in)
         $display("hsl_to_rgb_converter test passed");
      else
         $display("hsl_to_rgb_converter test failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400000;
      $display("Timeout with %0d results outstanding.", rgb_expected.size());
      $display("hsl_to_rgb_converter test failed");
      $finish;
   end

endmodule
